// ----- design/key_sequence_binding_matcher_macros.svh -----
// ----------------------------------------------------------------------------
// Key sequence binding matcher: assertion macros
// Concurrent assertion wrappers, clocked on i_clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef KEY_SEQUENCE_BINDING_MATCHER_MACROS_SVH
`define KEY_SEQUENCE_BINDING_MATCHER_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every edge.
`define KSBM_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// Trigger at one edge implies a consequence at the next edge.
`define KSBM_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);
`else
`define KSBM_ASSERT(lbl, cond, msg)
`define KSBM_ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

// ----- design/ksbm_pkg.sv -----
// ----------------------------------------------------------------------------
// Key sequence binding matcher package
// Shared sizes, codes, key type and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package ksbm_pkg;
    localparam int BUF_DEPTH  = 32;
    localparam int MAX_BIND   = 32;
    localparam int CHAIN_MAX  = 16;
    localparam int SYM_W      = 31;
    localparam int MOD_W      = 10;
    localparam logic [MOD_W-1:0] KEEP_MODS = 10'h3C3;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [MOD_W-1:0] modf;
    } t_key;

    typedef enum logic [1:0] {
        CMD_KEY    = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_HEADER = 2'd2,
        CMD_CHAIN  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_FALLBACK = 3'd0,
        KIND_FIRED    = 3'd1,
        KIND_ARG      = 3'd2,
        KIND_WAITING  = 3'd3,
        KIND_DROPPED  = 3'd4
    } t_kind;

    localparam logic CFG_BIND_COUNT = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BIND,
        S_RD,
        S_EV,
        S_FIRE,
        S_ARG_RD,
        S_ARG_EM,
        S_SH_RD,
        S_SH_WR,
        S_FL_RD,
        S_FL_EM,
        S_ONE
    } t_state;
endpackage
`default_nettype wire

// ----- design/ksbm_key_match.sv -----
// ----------------------------------------------------------------------------
// Key compare unit
// Two keys are equal when the symbols match and the modifier bits kept by
// KEEP_MODS overlap, or both modifier words are zero.
// ----------------------------------------------------------------------------
`default_nettype none
module ksbm_key_match (
    input  ksbm_pkg::t_key i_chain_key,
    input  ksbm_pkg::t_key i_buf_key,
    output logic           o_same
);
    import ksbm_pkg::*;

    logic w_overlap;
    logic w_both_zero;

    // Modifier rule, then symbol equality.
    assign w_overlap   = |(i_chain_key.modf & i_buf_key.modf & KEEP_MODS);
    assign w_both_zero = (i_chain_key.modf == '0) && (i_buf_key.modf == '0);
    assign o_same      = (i_chain_key.sym == i_buf_key.sym) && (w_overlap || w_both_zero);
endmodule
`default_nettype wire

// ----- design/key_sequence_binding_matcher.sv -----
// ----------------------------------------------------------------------------
// Key sequence binding matcher
// Buffers key events and matches them against a table of key bindings.
// ----------------------------------------------------------------------------
// One item at a time. Table writes and ticks are handled in the idle state; a
// tick that times out flushes the buffered keys one by one. A key event scans the
// active bindings one key comparison at a time through a single compare unit; a
// fired binding then emits its argument keys and the buffer is shifted down. The
// key buffer and the chain store are memories with a separate write port and a
// registered read port. Results leave through an output register; a transaction
// may give none, one or several.
`default_nettype none
`include "key_sequence_binding_matcher_macros.svh"
module key_sequence_binding_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: key_sym[30:0], key_mod[40:31], current_mode[48:41], elapsed[64:49],
    // entry_index[69:65], key_position[73:70], chain_length[78:74],
    // argument_count[84:79], mode_mask[92:85], zero pad[95:93]
    input  logic [95:0] s_tdata,
    // tuser: command[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: out_sym[30:0], out_mod[40:31], binding_index[45:41], zero pad[47:46]
    output logic [47:0] m_tdata,
    // tuser: kind[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import ksbm_pkg::*;

    // Input field unpacking.
    logic [SYM_W-1:0] w_sym;
    logic [MOD_W-1:0] w_mod;
    logic [7:0]       w_mode;
    logic [15:0]      w_elapsed;
    logic [4:0]       w_entry;
    logic [3:0]       w_pos;
    logic [4:0]       w_clen;
    logic [5:0]       w_acnt;
    logic [7:0]       w_mmask;
    assign w_sym     = s_tdata[30:0];
    assign w_mod     = s_tdata[40:31];
    assign w_mode    = s_tdata[48:41];
    assign w_elapsed = s_tdata[64:49];
    assign w_entry   = s_tdata[69:65];
    assign w_pos     = s_tdata[73:70];
    assign w_clen    = s_tdata[78:74];
    assign w_acnt    = s_tdata[84:79];
    assign w_mmask   = s_tdata[92:85];

    // Configuration registers.
    logic [5:0]  r_bind_count;
    logic [15:0] r_timeout;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bind_count <= 6'd0;
            r_timeout    <= 16'd1000;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_BIND_COUNT) begin
                r_bind_count <= i_cfg_data[5:0];
            end else begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // Control state.
    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [31:0] r_timer, n_timer;
    logic        r_waiting, n_waiting;
    logic [5:0]  r_i, n_i;
    logic [4:0]  r_b, n_b;
    logic [5:0]  r_nb, n_nb;
    logic [7:0]  r_mode, n_mode;
    logic        r_anyp, n_anyp;
    logic [5:0]  r_total, n_total;
    t_kind       r_x_kind, n_x_kind;
    t_key        r_x_key, n_x_key;

    // Output register.
    logic        r_ovalid, n_ovalid;
    t_kind       r_okind, n_okind;
    t_key        r_okey, n_okey;
    logic [4:0]  r_oidx, n_oidx;
    logic        r_olast, n_olast;

    // Binding header table.
    logic [4:0] r_hdr_len  [MAX_BIND];
    logic [5:0] r_hdr_arg  [MAX_BIND];
    logic [7:0] r_hdr_mask [MAX_BIND];
    logic       w_hdr_we;
    always_ff @(posedge i_clk) begin
        if (w_hdr_we) begin
            r_hdr_len[w_entry]  <= (w_clen > 5'(CHAIN_MAX)) ? 5'(CHAIN_MAX) : w_clen;
            r_hdr_arg[w_entry]  <= w_acnt;
            r_hdr_mask[w_entry] <= w_mmask;
        end
    end

    // Chain key memory, addressed by binding and position.
    t_key       r_chain_mem [MAX_BIND*CHAIN_MAX];
    t_key       r_chain_rd;
    logic       w_chain_we;
    always_ff @(posedge i_clk) begin
        if (w_chain_we) begin
            r_chain_mem[{w_entry, w_pos}] <= '{sym: w_sym, modf: w_mod};
        end
        r_chain_rd <= r_chain_mem[{r_b, r_i[3:0]}];
    end

    // Key buffer memory.
    t_key       r_buf_mem [BUF_DEPTH];
    t_key       r_buf_rd;
    logic       w_buf_we;
    logic [4:0] w_buf_waddr;
    t_key       w_buf_wdata;
    always_ff @(posedge i_clk) begin
        if (w_buf_we) begin
            r_buf_mem[w_buf_waddr] <= w_buf_wdata;
        end
        r_buf_rd <= r_buf_mem[r_i[4:0]];
    end

    // Shared key compare unit.
    logic w_same;
    ksbm_key_match u_match (
        .i_chain_key (r_chain_rd),
        .i_buf_key   (r_buf_rd),
        .o_same      (w_same)
    );

    // Per-binding quantities for the current scan entry.
    logic [5:0]  w_len6;
    logic [5:0]  w_limit;
    logic [6:0]  w_need;
    logic        w_fits;
    logic        w_slot;
    logic [32:0] w_tsum;
    logic [31:0] w_tsat;
    assign w_len6  = {1'b0, r_hdr_len[r_b]};
    assign w_limit = (w_len6 < r_fill) ? w_len6 : r_fill;
    assign w_need  = 7'(w_len6) + 7'(r_hdr_arg[r_b]);
    assign w_fits  = w_need <= 7'(r_fill);
    assign w_slot  = !r_ovalid || m_tready;
    assign w_tsum  = 33'(r_timer) + 33'(w_elapsed);
    assign w_tsat  = w_tsum[32] ? 32'hFFFF_FFFF : w_tsum[31:0];

    assign s_tready = (r_state == S_IDLE);

    // Sequencer: next state and datapath controls.
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_timer   = r_timer;
        n_waiting = r_waiting;
        n_i       = r_i;
        n_b       = r_b;
        n_nb      = r_nb;
        n_mode    = r_mode;
        n_anyp    = r_anyp;
        n_total   = r_total;
        n_x_kind  = r_x_kind;
        n_x_key   = r_x_key;
        n_ovalid  = r_ovalid && !m_tready;
        n_okind   = r_okind;
        n_okey    = r_okey;
        n_oidx    = r_oidx;
        n_olast   = r_olast;
        w_hdr_we    = 1'b0;
        w_chain_we  = 1'b0;
        w_buf_we    = 1'b0;
        w_buf_waddr = r_fill[4:0];
        w_buf_wdata = '{sym: w_sym, modf: w_mod & KEEP_MODS};
        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (t_cmd'(s_tuser))
                        CMD_KEY: begin
                            if (r_fill >= 6'(BUF_DEPTH)) begin
                                n_x_kind = KIND_DROPPED;
                                n_x_key  = '{sym: w_sym, modf: w_mod & KEEP_MODS};
                                n_state  = S_ONE;
                            end else begin
                                w_buf_we = 1'b1;
                                n_fill   = r_fill + 6'd1;
                                n_mode   = w_mode;
                                n_b      = 5'd0;
                                n_anyp   = 1'b0;
                                n_nb     = (r_bind_count > 6'(MAX_BIND)) ? 6'(MAX_BIND)
                                                                         : r_bind_count;
                                n_state  = S_BIND;
                            end
                        end
                        CMD_TICK: begin
                            n_timer = w_tsat;
                            if (w_tsat > 32'(r_timeout) && r_waiting) begin
                                if (r_fill == 6'd0) begin
                                    n_waiting = 1'b0;
                                end else begin
                                    n_i     = 6'd0;
                                    n_state = S_FL_RD;
                                end
                            end
                        end
                        CMD_HEADER: w_hdr_we = 1'b1;
                        CMD_CHAIN:  w_chain_we = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_BIND: begin
                n_i = 6'd0;
                if (6'(r_b) == r_nb || (r_b == 5'(MAX_BIND - 1) && r_nb == 6'd0)) begin
                    if (r_anyp) begin
                        n_x_kind = KIND_WAITING;
                        n_x_key  = '0;
                        n_state  = S_ONE;
                    end else begin
                        n_state = S_FL_RD;
                    end
                end else if ((r_hdr_mask[r_b] & r_mode) == 8'd0) begin
                    n_b     = r_b + 5'd1;
                    n_state = (6'(r_b) + 6'd1 == r_nb) ? S_BIND : S_BIND;
                    if (6'(r_b) + 6'd1 == r_nb) begin
                        n_b = r_b;
                        n_state = S_BIND;
                        n_nb = 6'(r_b);
                    end
                end else if (w_limit == 6'd0) begin
                    n_anyp = 1'b1;
                    if (w_fits) begin
                        n_state = S_FIRE;
                    end else if (6'(r_b) + 6'd1 == r_nb) begin
                        n_nb = 6'(r_b);
                    end else begin
                        n_b = r_b + 5'd1;
                    end
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_EV;
            S_EV: begin
                if (!w_same || (r_i + 6'd1 == w_limit)) begin
                    if (w_same) begin
                        n_anyp = 1'b1;
                    end
                    if (w_same && w_fits) begin
                        n_state = S_FIRE;
                    end else begin
                        n_state = S_BIND;
                        n_i     = 6'd0;
                        if (6'(r_b) + 6'd1 == r_nb) begin
                            n_nb = 6'(r_b);
                        end else begin
                            n_b = r_b + 5'd1;
                        end
                    end
                end else begin
                    n_i     = r_i + 6'd1;
                    n_state = S_RD;
                end
            end
            S_FIRE: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_FIRED;
                    n_okey   = '0;
                    n_oidx   = r_b;
                    n_olast  = (r_hdr_arg[r_b] == 6'd0);
                    n_total  = w_need[5:0];
                    n_i      = w_len6;
                    n_state  = (r_hdr_arg[r_b] == 6'd0) ? S_SH_RD : S_ARG_RD;
                    if (r_hdr_arg[r_b] == 6'd0) begin
                        n_i = w_need[5:0];
                    end
                end
            end
            S_ARG_RD: n_state = S_ARG_EM;
            S_ARG_EM: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_ARG;
                    n_okey   = r_buf_rd;
                    n_oidx   = 5'd0;
                    n_olast  = (r_i + 6'd1 == r_total);
                    n_i      = r_i + 6'd1;
                    n_state  = (r_i + 6'd1 == r_total) ? S_SH_RD : S_ARG_RD;
                end
            end
            S_SH_RD: begin
                if (r_i >= r_fill) begin
                    n_fill  = r_fill - r_total;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SH_WR;
                end
            end
            S_SH_WR: begin
                w_buf_we    = 1'b1;
                w_buf_waddr = 5'(r_i - r_total);
                w_buf_wdata = r_buf_rd;
                n_i         = r_i + 6'd1;
                n_state     = S_SH_RD;
            end
            S_FL_RD: begin
                if (r_i == r_fill) begin
                    n_fill    = 6'd0;
                    n_waiting = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_FL_EM;
                end
            end
            S_FL_EM: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_okind  = KIND_FALLBACK;
                    n_okey   = r_buf_rd;
                    n_oidx   = 5'd0;
                    n_olast  = (r_i + 6'd1 == r_fill);
                    n_i      = r_i + 6'd1;
                    n_state  = S_FL_RD;
                end
            end
            S_ONE: begin
                if (w_slot) begin
                    n_ovalid = 1'b1;
                    n_okind  = r_x_kind;
                    n_okey   = r_x_key;
                    n_oidx   = 5'd0;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                    if (r_x_kind == KIND_WAITING) begin
                        n_waiting = 1'b1;
                        n_timer   = 32'd0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= 6'd0;
            r_timer   <= 32'd0;
            r_waiting <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_timer   <= n_timer;
            r_waiting <= n_waiting;
            r_ovalid  <= n_ovalid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_b      <= n_b;
        r_nb     <= n_nb;
        r_mode   <= n_mode;
        r_anyp   <= n_anyp;
        r_total  <= n_total;
        r_x_kind <= n_x_kind;
        r_x_key  <= n_x_key;
        r_okind  <= n_okind;
        r_okey   <= n_okey;
        r_oidx   <= n_oidx;
        r_olast  <= n_olast;
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = {2'b00, r_oidx, r_okey.modf, r_okey.sym};
    assign m_tuser  = r_okind;
    assign m_tlast  = r_olast;

    // Checks on the sequencer.
    `KSBM_ASSERT(a_fill_range, r_fill <= 6'(BUF_DEPTH), "buffer fill above depth")
    `KSBM_ASSERT(a_cmp_range, (r_state != S_EV) || (r_i < w_limit), "compare index past limit")
    `KSBM_ASSERT_NEXT(a_key_push, s_tvalid && s_tready && s_tuser == CMD_KEY && r_fill < 6'(BUF_DEPTH),
        r_fill == $past(r_fill) + 6'd1 && r_state == S_BIND, "key push did not start a scan")
    `KSBM_ASSERT_NEXT(a_wait_flag, r_state == S_ONE && r_x_kind == KIND_WAITING && w_slot,
        r_waiting && r_timer == 32'd0, "waiting result without waiting state")
endmodule
`default_nettype wire
